FILE: rtl/srfb_pkg.sv
// ----------------------------------------------------------------------------
// srfb_pkg
// Types and constants shared by the sensor report frame builder.
// ----------------------------------------------------------------------------
package srfb_pkg;

    localparam int FRAME_MAX = 24;
    localparam int IDX_W     = $clog2(FRAME_MAX);
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DW    = 64;

    localparam logic [7:0] START_BYTE   = 8'h7E;
    localparam logic [7:0] FRAME_TYPE   = 8'h10;
    localparam logic [7:0] FRAME_ID     = 8'h01;
    localparam logic [7:0] LEN_BASE     = 8'd17;
    localparam logic [7:0] CKSUM_BASE   = 8'hFF;
    localparam logic [7:0] ID_THREE_INF = 8'd2;

    localparam logic [63:0] LONG_RESET  = 64'h0;
    localparam logic [15:0] SHORT_RESET = 16'hFFFE;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_LONG  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_SHORT = CFG_IDX_W'(1);

    // byte positions within the frame
    localparam logic [IDX_W-1:0] POS_START     = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_LEN_HI    = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_LEN_LO    = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_TYPE      = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_FRAME_ID  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_LONG_MSB  = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_LONG_LSB  = IDX_W'(12);
    localparam logic [IDX_W-1:0] POS_SHORT_HI  = IDX_W'(13);
    localparam logic [IDX_W-1:0] POS_SHORT_LO  = IDX_W'(14);
    localparam logic [IDX_W-1:0] POS_RADIUS    = IDX_W'(15);
    localparam logic [IDX_W-1:0] POS_OPTIONS   = IDX_W'(16);
    localparam logic [IDX_W-1:0] POS_SENSOR_ID = IDX_W'(17);
    localparam logic [IDX_W-1:0] POS_STATE     = IDX_W'(18);
    localparam logic [IDX_W-1:0] POS_INFO1     = IDX_W'(19);
    localparam logic [IDX_W-1:0] POS_INFO2     = IDX_W'(20);
    localparam logic [IDX_W-1:0] POS_INFO3     = IDX_W'(21);
    localparam logic [IDX_W-1:0] POS_TAIL      = IDX_W'(22);
    localparam logic [IDX_W-1:0] POS_TAIL_EXT  = IDX_W'(23);

    typedef struct packed {
        logic [7:0] sensor_id;
        logic [7:0] sensor_state;
        logic [7:0] info_first;
        logic [7:0] info_second;
        logic [7:0] info_third;
    } report_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
    } frame_beat_t;

    // what the byte selector tells the sequencer about the current position
    typedef struct packed {
        logic [7:0] data;
        logic       in_sum;
        logic       is_cksum;
    } byte_info_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } seq_state_t;

endpackage

FILE: rtl/srfb_byte_sel.sv
// ----------------------------------------------------------------------------
// srfb_byte_sel
// Picks the frame byte at a given position from the held report and addresses.
// ----------------------------------------------------------------------------
module srfb_byte_sel
    import srfb_pkg::*;
(
    input  logic [IDX_W-1:0] idx,
    input  report_t          report,
    input  logic [63:0]      dest_long,
    input  logic [15:0]      dest_short,
    output byte_info_t       info
);

    logic       three_info;
    logic [2:0] long_k;
    logic [2:0] long_sel;

    assign three_info = (report.sensor_id == ID_THREE_INF);
    assign long_k     = 3'(idx - POS_LONG_MSB);
    assign long_sel   = 3'(3'd7 - long_k);

    always_comb begin
        info.data     = 8'h00;
        info.in_sum   = 1'b1;
        info.is_cksum = 1'b0;
        case (idx) inside
            POS_START: begin
                info.data   = START_BYTE;
                info.in_sum = 1'b0;
            end
            POS_LEN_HI: begin
                info.in_sum = 1'b0;
            end
            POS_LEN_LO: begin
                info.data   = three_info ? 8'(LEN_BASE + 8'd3) : 8'(LEN_BASE + 8'd2);
                info.in_sum = 1'b0;
            end
            POS_TYPE:                     info.data = FRAME_TYPE;
            POS_FRAME_ID:                 info.data = FRAME_ID;
            [POS_LONG_MSB:POS_LONG_LSB]:  info.data = dest_long[{long_sel, 3'b000} +: 8];
            POS_SHORT_HI:                 info.data = dest_short[15:8];
            POS_SHORT_LO:                 info.data = dest_short[7:0];
            POS_RADIUS, POS_OPTIONS:      info.data = 8'h00;
            POS_SENSOR_ID:                info.data = report.sensor_id;
            POS_STATE:                    info.data = report.sensor_state;
            POS_INFO1:                    info.data = report.info_first;
            POS_INFO2:                    info.data = report.info_second;
            POS_INFO3:                    info.data = three_info ? report.info_third : 8'h00;
            POS_TAIL: begin
                // zero pad for id 2, checksum otherwise
                info.in_sum   = three_info;
                info.is_cksum = !three_info;
            end
            POS_TAIL_EXT: begin
                info.in_sum   = 1'b0;
                info.is_cksum = 1'b1;
            end
            default: begin
                info.in_sum   = 1'b0;
                info.is_cksum = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/srfb_cksum.sv
// ----------------------------------------------------------------------------
// srfb_cksum
// Shared 8-bit adder accumulating the checksum, one byte per add_en beat.
// ----------------------------------------------------------------------------
module srfb_cksum
    import srfb_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       clear,
    input  logic       add_en,
    input  logic [7:0] add_byte,
    output logic [7:0] cksum
);

    logic [7:0] sum_reg;
    logic [7:0] sum_next;

    always_comb begin
        sum_next = sum_reg;
        if (clear) begin
            sum_next = 8'h00;
        end else if (add_en) begin
            sum_next = 8'(sum_reg + add_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= 8'h00;
        end else begin
            sum_reg <= sum_next;
        end
    end

    assign cksum = 8'(CKSUM_BASE - sum_reg);

endmodule

FILE: rtl/sensor_report_frame_builder.sv
// ----------------------------------------------------------------------------
// sensor_report_frame_builder
// Turns one sensor report into the bytes of a radio transmit-request frame.
// ----------------------------------------------------------------------------
// Usage: a report beat on s_* is taken when s_valid and s_ready are high.
// The block then sends the frame one byte per m_* beat, with m_payload.last
// set on the checksum byte: 23 beats, or 24 when the sensor id is 2.
// The report is registered when taken; the sequencer then enters its send
// state and loads the bytes into the output register, a byte leaving every
// cycle while m_ready is held high. s_ready is high only while no frame is
// being built; the next report may be taken while the checksum byte still
// waits in the output register. A stalled m_ready holds the current byte and
// pauses the sequencer. The destination addresses are to be written on cfg_*
// only while idle, which the block does not enforce; they then take effect
// on the next frame. Writes to unknown indexes are dropped. Reset (aresetn
// low, synchronous) empties the output, returns to idle and sets the long
// address to 0 and the short address to 0xFFFE.
// ----------------------------------------------------------------------------
module sensor_report_frame_builder
    import srfb_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  report_t              s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output frame_beat_t          m_payload
);

    seq_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    report_t          report_reg;
    logic [63:0]      long_reg;
    logic [15:0]      short_reg;
    logic             m_valid_reg, m_valid_next;
    frame_beat_t      beat_reg, beat_next;

    byte_info_t       info;
    logic [7:0]       cksum;
    logic             accept;
    logic             load;

    assign accept = s_valid && s_ready;
    assign load   = (state_reg == ST_SEND) && (!m_valid_reg || m_ready);

    srfb_byte_sel u_byte_sel (
        .idx        (idx_reg),
        .report     (report_reg),
        .dest_long  (long_reg),
        .dest_short (short_reg),
        .info       (info)
    );

    srfb_cksum u_cksum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (accept),
        .add_en   (load && info.in_sum),
        .add_byte (info.data),
        .cksum    (cksum)
    );

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        beat_next    = beat_reg;
        s_ready      = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SEND;
                    idx_next   = POS_START;
                end
            end
            ST_SEND: begin
                if (load) begin
                    m_valid_next         = 1'b1;
                    beat_next.frame_byte = info.is_cksum ? cksum : info.data;
                    beat_next.last       = info.is_cksum;
                    idx_next             = IDX_W'(idx_reg + 1'b1);
                    if (info.is_cksum) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= POS_START;
            m_valid_reg <= 1'b0;
            long_reg    <= LONG_RESET;
            short_reg   <= SHORT_RESET;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && cfg_index == CFG_DEST_LONG) begin
                long_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_DEST_SHORT) begin
                short_reg <= cfg_wdata[15:0];
            end
        end
    end

    // payload holding, no reset needed
    always_ff @(posedge aclk) begin
        beat_reg <= beat_next;
        if (accept) begin
            report_reg <= s_payload;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = beat_reg;

`ifndef NO_ASSERTIONS
    // busy straight after a report is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("report taken while a frame is still being built");

    // the byte counter never runs past the longest frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> (idx_reg <= POS_TAIL_EXT))
        else $error("byte counter beyond frame end");

    // loading the checksum byte ends the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (load && info.is_cksum) |=> (state_reg == ST_IDLE && m_valid && m_payload.last))
        else $error("checksum byte did not close the frame");
`endif

endmodule

FILE: verif/sensor_report_frame_builder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_report_frame_builder_test
// Sends sensor reports to the frame builder and checks each frame byte it
// returns against a frame assembled here from the report and the current
// destination addresses. Both sides idle and stall at random outside the
// back-to-back test. Addresses are rewritten between phases when idle.
// ----------------------------------------------------------------------------
module sensor_report_frame_builder_test;
    import srfb_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [7:0]  SOF          = 8'h7E;
    localparam logic [7:0]  API_TX_REQ   = 8'h10;
    localparam logic [7:0]  TX_FRAME_ID  = 8'h01;
    localparam logic [7:0]  LEN_FIXED    = 8'd17;
    localparam logic [7:0]  SUM_FROM     = 8'hFF;
    localparam logic [7:0]  ID_EXTRA_INF = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_LOW  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_HIGH = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DW-1:0]    cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    report_t              s_payload;
    logic                 m_valid;
    logic                 m_ready;
    frame_beat_t          m_payload;

    // local copy of the address registers
    logic [63:0]  dest_long_q;
    logic [15:0]  dest_short_q;

    frame_beat_t  frame_bytes_due[$];
    int           mismatches;
    int           cycle_count;
    int           beat_index;
    bit           src_idle_en;
    bit           snk_idle_en;

    sensor_report_frame_builder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sensor_report_frame_builder verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= snk_idle_en ? ($urandom_range(0, 99) >= 15) : 1'b1;
    end

    // assemble the frame for one report and queue its bytes
    function automatic void build_frame(input report_t r);
        logic [7:0] bytes[$];
        logic [7:0] sum;
        frame_beat_t beat;
        bit extra_info;
        extra_info = (r.sensor_id == ID_EXTRA_INF);
        bytes.push_back(SOF);
        bytes.push_back(8'h00);
        bytes.push_back(LEN_FIXED + (extra_info ? 8'd3 : 8'd2));
        bytes.push_back(API_TX_REQ);
        bytes.push_back(TX_FRAME_ID);
        for (int k = 7; k >= 0; k--)
            bytes.push_back(dest_long_q[8*k +: 8]);
        bytes.push_back(dest_short_q[15:8]);
        bytes.push_back(dest_short_q[7:0]);
        bytes.push_back(8'h00);         // radius
        bytes.push_back(8'h00);         // options
        bytes.push_back(r.sensor_id);
        bytes.push_back(r.sensor_state);
        bytes.push_back(r.info_first);
        bytes.push_back(r.info_second);
        if (extra_info)
            bytes.push_back(r.info_third);
        bytes.push_back(8'h00);
        // checksum covers everything after the length field
        sum = 8'h00;
        for (int k = 3; k < bytes.size(); k++)
            sum += bytes[k];
        bytes.push_back(SUM_FROM - sum);
        for (int k = 0; k < bytes.size(); k++) begin
            beat.frame_byte = bytes[k];
            beat.last       = (k == bytes.size() - 1);
            frame_bytes_due.push_back(beat);
        end
    endfunction

    // predict on every accepted report, check every accepted byte
    always @(posedge aclk) begin
        frame_beat_t want;
        if (aresetn) begin
            if (s_valid && s_ready === 1'b1)
                build_frame(s_payload);
            if (m_valid === 1'b1 && m_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $display("%0t: unexpected frame beat, expected none, got byte %02h last %b",
                             $time, m_payload.frame_byte, m_payload.last);
                    mismatches++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (m_payload.frame_byte !== want.frame_byte) begin
                        $display("%0t: beat %0d frame_byte expected %02h, got %02h",
                                 $time, beat_index, want.frame_byte, m_payload.frame_byte);
                        mismatches++;
                    end
                    if (m_payload.last !== want.last) begin
                        $display("%0t: beat %0d last expected %b, got %b",
                                 $time, beat_index, want.last, m_payload.last);
                        mismatches++;
                    end
                    beat_index = want.last ? 0 : beat_index + 1;
                end
            end
        end
    end

    // entered and left at a falling edge; valid stays up for a following beat
    task automatic send_report(input report_t r);
        if (src_idle_en) begin
            while ($urandom_range(0, 99) < 15) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_payload <= r;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic send_fields(input logic [7:0] id, input logic [7:0] st,
                               input logic [7:0] i1, input logic [7:0] i2,
                               input logic [7:0] i3);
        report_t r;
        r.sensor_id    = id;
        r.sensor_state = st;
        r.info_first   = i1;
        r.info_second  = i2;
        r.info_third   = i3;
        send_report(r);
    endtask

    task automatic stop_reports();
        s_valid <= 1'b0;
    endtask

    task automatic wait_frames_done();
        while (frame_bytes_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == CFG_DEST_LONG)
            dest_long_q = data;
        else if (idx == CFG_DEST_SHORT)
            dest_short_q = data[15:0];
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic report_t random_report();
        report_t r;
        case ($urandom_range(0, 9))
            0, 1, 2: r.sensor_id = ID_EXTRA_INF;
            3, 4, 5: r.sensor_id = 8'($urandom_range(1, 4));
            default: r.sensor_id = 8'($urandom);
        endcase
        r.sensor_state = 8'($urandom);
        r.info_first   = 8'($urandom);
        r.info_second  = 8'($urandom);
        r.info_third   = 8'($urandom);
        return r;
    endfunction

    task automatic test_reset_addresses();
        send_fields(8'd1, 8'h01, 8'h20, 8'h30, 8'h00);
        stop_reports();
        wait_frames_done();
    endtask

    task automatic test_report_fields();
        send_fields(8'd0,   8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(8'd1,   8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_fields(8'd2,   8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_fields(8'd2,   8'h00, 8'h00, 8'h00, 8'h00);
        send_fields(8'd3,   8'hAA, 8'h55, 8'hAA, 8'h55);
        send_fields(8'd4,   8'h55, 8'hAA, 8'h55, 8'hAA);
        send_fields(8'd5,   8'h12, 8'h34, 8'h56, 8'h78);
        send_fields(8'd255, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        // third byte must be dropped for ids other than 2
        send_fields(8'd3,   8'h01, 8'h02, 8'h03, 8'hEE);
        send_fields(8'd2,   8'h80, 8'h7F, 8'h01, 8'hFE);
        send_fields(8'd130, 8'h80, 8'h01, 8'h80, 8'h01);
        stop_reports();
        wait_frames_done();
    endtask

    task automatic test_address_registers();
        write_reg(CFG_DEST_LONG,  64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_DEST_SHORT, 64'h0000_0000_0000_0000);
        send_fields(8'd2, 8'h11, 8'h22, 8'h33, 8'h44);
        send_fields(8'd1, 8'hFF, 8'h00, 8'hFF, 8'h00);
        stop_reports();
        wait_frames_done();
        write_reg(CFG_DEST_LONG,  64'h0123_4567_89AB_CDEF);
        write_reg(CFG_DEST_SHORT, 64'hFFFF_FFFF_FFFF_A55A);
        send_fields(8'd4, 8'h0F, 8'hF0, 8'h3C, 8'hC3);
        stop_reports();
        wait_frames_done();
        // writes to unknown indexes leave both addresses alone
        write_reg(CFG_NO_REG_LOW,  64'hDEAD_BEEF_DEAD_BEEF);
        write_reg(CFG_NO_REG_HIGH, 64'h5A5A_5A5A_5A5A_5A5A);
        send_fields(8'd2, 8'hC3, 8'h3C, 8'hF0, 8'h0F);
        stop_reports();
        wait_frames_done();
        write_reg(CFG_DEST_LONG,  64'h0);
        write_reg(CFG_DEST_SHORT, 64'hFFFF);
        send_fields(8'd1, 8'h00, 8'h00, 8'h00, 8'h00);
        stop_reports();
        wait_frames_done();
    endtask

    task automatic test_back_to_back();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        for (int n = 0; n < 40; n++)
            send_report(random_report());
        stop_reports();
        wait_frames_done();
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    task automatic test_random_reports();
        for (int n = 0; n < 280; n++) begin
            if (n % 70 == 69) begin
                stop_reports();
                wait_frames_done();
                case ($urandom_range(0, 2))
                    0: begin
                        write_reg(CFG_DEST_LONG,  '1);
                        write_reg(CFG_DEST_SHORT, 64'h0);
                    end
                    1: begin
                        write_reg(CFG_DEST_LONG,  64'h0);
                        write_reg(CFG_DEST_SHORT, 64'hFFFF);
                    end
                    default: begin
                        write_reg(CFG_DEST_LONG,  {$urandom, $urandom});
                        write_reg(CFG_DEST_SHORT, 64'($urandom_range(0, 65535)));
                    end
                endcase
            end else if ($urandom_range(0, 39) == 0) begin
                // hold off until the output side has caught up
                stop_reports();
                wait_frames_done();
            end
            send_report(random_report());
        end
        stop_reports();
        wait_frames_done();
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_payload    = '0;
        m_ready      = 1'b0;
        dest_long_q  = 64'h0;
        dest_short_q = 16'hFFFE;
        mismatches   = 0;
        cycle_count  = 0;
        beat_index   = 0;
        src_idle_en  = 1'b1;
        snk_idle_en  = 1'b1;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_addresses();
        test_report_fields();
        test_address_registers();
        test_back_to_back();
        test_random_reports();

        repeat (30) @(posedge aclk);
        if (mismatches == 0 && frame_bytes_due.size() == 0)
            $display("sensor_report_frame_builder verification clean");
        else
            $display("sensor_report_frame_builder verification failed");
        $finish;
    end

endmodule
